/* rtl/assert_macros.svh */
// assertion helpers used by the rtl checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on the rising clock edge, quiet while reset is applied
`define PB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form: antecedent holds, consequent must hold in the same cycle
`define PB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle form: antecedent holds, consequent must hold in the following cycle
`define PB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pbrle_pkg.sv */
// ----------------------------------------------------------------------------
// pbrle_pkg
// Shared types and constants of the packbits run-length decoder.
// ----------------------------------------------------------------------------
package pbrle_pkg;

	localparam int unsigned CNT_W    = 17;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OUT_W    = 40;

	// decoded bytes a page needs before it can close at a packet end
	localparam logic [CNT_W-1:0] PAGE_BYTES = 17'd32768;
	localparam logic [CNT_W-1:0] CNT_MAX    = 17'h1FFFF;
	localparam logic [BYTE_W-1:0] SIGN_BIT  = 8'h80;
	localparam logic [BYTE_W:0]  REPEAT_BASE = 9'd258;

	typedef struct packed {
		logic [BYTE_W-1:0] run_value;
		logic [BYTE_W-1:0] run_length;
		logic              page_done;
		logic [CNT_W-1:0]  bytes_consumed;
	} run_t;

endpackage

/* rtl/packbits_run_length_decoder_core.sv */
// ----------------------------------------------------------------------------
// packbits_run_length_decoder_core
// PackBits-style run-length decoder, one compressed byte per transaction.
// ----------------------------------------------------------------------------
// Slave side takes the compressed stream, one byte per transaction in s_tdata.
// Control bytes start a packet and produce nothing; each data byte produces one
// run on the master side: value, length (1 for literal bytes, 3..130 for a
// repeat) and, on the run that ends the page packet, tlast with the count of
// compressed bytes consumed for the page.
// An accepted byte passes the input register and the phase machine into the
// result register behind m_tvalid. Throughput is one byte per cycle while the
// receiver is ready; the phase machine and counters update in the single decode
// step, so back-to-back bytes never wait on each other.
// When the receiver stalls, the result register holds its run, the input
// register keeps one more byte, and s_tready drops only once both are full.
// Reset clears the phase machine, the page counters and both valid flags; the
// block is ready to accept from the first cycle after reset is released.
// ----------------------------------------------------------------------------
module packbits_run_length_decoder_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [pbrle_pkg::BYTE_W-1:0] s_tdata,  // [7:0] in_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pbrle_pkg::OUT_W-1:0]  m_tdata,  // [7:0] run_value, [15:8] run_length,
	                                               // [32:16] bytes_consumed, [39:33] zero
	output logic                         m_tlast   // page_done
);

	logic                         valid_s1;
	logic [pbrle_pkg::BYTE_W-1:0] byte_s1;
	logic                         advance;
	logic                         fire;
	logic                         run_valid;
	pbrle_pkg::run_t              run;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	pbrle_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.in_byte   (byte_s1),
		.run_valid (run_valid),
		.run       (run)
	);

	pbrle_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.run_valid (fire && run_valid),
		.run       (run),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

/* rtl/pbrle_decode.sv */
// ----------------------------------------------------------------------------
// pbrle_decode
// Packet phase machine and page counters; turns one byte into at most one run.
// ----------------------------------------------------------------------------
module pbrle_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [pbrle_pkg::BYTE_W-1:0] in_byte,
	output logic                         run_valid,
	output pbrle_pkg::run_t              run
);

	typedef enum logic [1:0] {
		PH_CTRL    = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	phase_t                         phase_q, phase_d;
	logic [pbrle_pkg::BYTE_W-1:0]   literal_left_q, literal_left_d;
	logic [pbrle_pkg::BYTE_W-1:0]   repeat_len_q, repeat_len_d;
	logic [pbrle_pkg::CNT_W-1:0]    out_total_q, out_total_d;
	logic [pbrle_pkg::CNT_W-1:0]    in_total_q, in_total_d, in_total_inc;
	logic [pbrle_pkg::BYTE_W-1:0]   lit_dec;
	logic                           packet_end;
	logic                           done;

	assign in_total_inc = (in_total_q != pbrle_pkg::CNT_MAX) ?
		in_total_q + 17'd1 : in_total_q;
	assign lit_dec = (literal_left_q != '0) ? literal_left_q - 8'd1 : literal_left_q;

	always_comb begin
		phase_d         = phase_q;
		literal_left_d  = literal_left_q;
		repeat_len_d    = repeat_len_q;
		out_total_d     = out_total_q;
		in_total_d      = in_total_inc;
		run_valid       = 1'b0;
		packet_end      = 1'b0;
		run.run_value   = in_byte;
		run.run_length  = 8'd1;
		case (phase_q)
			PH_REPEAT: begin
				run_valid      = 1'b1;
				packet_end     = 1'b1;
				run.run_length = repeat_len_q;
				out_total_d    = out_total_q + {9'd0, repeat_len_q};
				repeat_len_d   = '0;
				phase_d        = PH_CTRL;
			end
			PH_LITERAL: begin
				run_valid      = 1'b1;
				out_total_d    = out_total_q + 17'd1;
				literal_left_d = lit_dec;
				if (lit_dec == '0) begin
					packet_end = 1'b1;
					phase_d    = PH_CTRL;
				end
			end
			default: begin
				// control byte, sign bit picks repeat or literal packet
				if ((in_byte & pbrle_pkg::SIGN_BIT) != '0) begin
					repeat_len_d = 8'(pbrle_pkg::REPEAT_BASE - {1'b0, in_byte});
					phase_d      = PH_REPEAT;
				end else begin
					literal_left_d = in_byte + 8'd1;
					phase_d        = PH_LITERAL;
				end
			end
		endcase
		done               = packet_end && (out_total_d >= pbrle_pkg::PAGE_BYTES);
		run.page_done      = done;
		run.bytes_consumed = done ? in_total_d : '0;
		if (done) begin
			phase_d        = PH_CTRL;
			literal_left_d = '0;
			repeat_len_d   = '0;
			out_total_d    = '0;
			in_total_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_CTRL;
			literal_left_q <= '0;
			repeat_len_q   <= '0;
			out_total_q    <= '0;
			in_total_q     <= '0;
		end else if (fire) begin
			phase_q        <= phase_d;
			literal_left_q <= literal_left_d;
			repeat_len_q   <= repeat_len_d;
			out_total_q    <= out_total_d;
			in_total_q     <= in_total_d;
		end
	end

endmodule

/* rtl/pbrle_out_stage.sv */
// ----------------------------------------------------------------------------
// pbrle_out_stage
// Result register on the master side; holds a run until the receiver takes it.
// ----------------------------------------------------------------------------
module pbrle_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        run_valid,
	input  pbrle_pkg::run_t             run,
	output logic                        m_tvalid,
	output logic [pbrle_pkg::OUT_W-1:0] m_tdata,
	output logic                        m_tlast
);

	logic            valid_q;
	pbrle_pkg::run_t run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= run_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && run_valid) begin
			run_q <= run;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = run_q.page_done;
	assign m_tdata  = {7'd0, run_q.bytes_consumed, run_q.run_length, run_q.run_value};

endmodule

/* rtl/pbrle_checker.sv */
// ----------------------------------------------------------------------------
// pbrle_assertions
// Port-level checks of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbrle_assertions (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [pbrle_pkg::OUT_W-1:0]  m_tdata,
	input logic                         m_tlast
);

	// a stalled run keeps its payload
	`PB_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled run changed")

	// run length is never zero and never beyond a repeat's maximum
	`PB_ASSERT_IMPL(a_len, clk, arst_n, m_tvalid, (m_tdata[15:8] != 8'd0) && (m_tdata[15:8] <= 8'd130), "run length out of range")

	// only the page-ending run carries a byte count, and that count is nonzero
	`PB_ASSERT_IMPL(a_count, clk, arst_n, m_tvalid, m_tlast ? (m_tdata[32:16] != 17'd0) : (m_tdata[32:16] == 17'd0), "bytes consumed mismatch with tlast")

	// input side backs up only while a finished run is waiting
	`PB_ASSERT_CLK(a_ready, clk, arst_n, s_tready || (m_tvalid && !m_tready), "input stalled without output backpressure")

	// upper pad bits stay zero
	`PB_ASSERT_IMPL(a_pad, clk, arst_n, m_tvalid, m_tdata[39:33] == 7'd0, "pad bits set")

endmodule

bind packbits_run_length_decoder_core pbrle_assertions u_pbrle_assertions (.*);

/* sim/pbrle_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrle_checker
// Watches both stream channels of the packbits decoder, tracks the decode of
// every accepted compressed byte and compares each run leaving the block
// against the oldest predicted run.
// ----------------------------------------------------------------------------
module pbrle_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [pbrle_pkg::BYTE_W-1:0] s_tdata,  // [7:0] in_byte
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [pbrle_pkg::OUT_W-1:0]  m_tdata,  // [7:0] run_value, [15:8] run_length,
	                                               // [32:16] bytes_consumed, [39:33] zero
	input  logic                         m_tlast,  // page_done
	output int                           mismatches,
	output int                           runs_waiting
);

	typedef enum logic [1:0] {
		WAIT_CTRL    = 2'd0,
		WAIT_REPEAT  = 2'd1,
		WAIT_LITERAL = 2'd2
	} decode_phase_t;

	decode_phase_t                 phase;
	logic [pbrle_pkg::BYTE_W-1:0]  literals_left;
	logic [pbrle_pkg::BYTE_W-1:0]  repeat_count;
	logic [pbrle_pkg::CNT_W-1:0]   decoded_total;
	logic [pbrle_pkg::CNT_W-1:0]   consumed_total;
	pbrle_pkg::run_t               predicted_runs[$];

	task automatic clear_page();
		phase          = WAIT_CTRL;
		literals_left  = '0;
		repeat_count   = '0;
		decoded_total  = '0;
		consumed_total = '0;
	endtask

	task automatic decode_byte(input logic [pbrle_pkg::BYTE_W-1:0] b);
		pbrle_pkg::run_t          r;
		logic                     has_run;
		logic                     packet_end;
		logic [pbrle_pkg::BYTE_W:0] rep_wide;
		r          = '0;
		has_run    = 1'b0;
		packet_end = 1'b0;
		if (consumed_total < pbrle_pkg::CNT_MAX)
			consumed_total = consumed_total + 1'b1;
		case (phase)
			WAIT_REPEAT: begin
				decoded_total = decoded_total + pbrle_pkg::CNT_W'(repeat_count);
				r.run_value   = b;
				r.run_length  = repeat_count;
				has_run       = 1'b1;
				packet_end    = 1'b1;
				phase         = WAIT_CTRL;
				repeat_count  = '0;
			end
			WAIT_LITERAL: begin
				decoded_total = decoded_total + 1'b1;
				if (literals_left != 0)
					literals_left = literals_left - 1'b1;
				r.run_value  = b;
				r.run_length = 8'd1;
				has_run      = 1'b1;
				packet_end   = (literals_left == 0);
				if (packet_end)
					phase = WAIT_CTRL;
			end
			default: begin
				// control byte: sign bit picks repeat or literal packet
				if ((b & pbrle_pkg::SIGN_BIT) != 0) begin
					rep_wide     = pbrle_pkg::REPEAT_BASE - {1'b0, b};
					repeat_count = rep_wide[pbrle_pkg::BYTE_W-1:0];
					phase        = WAIT_REPEAT;
				end else begin
					literals_left = b + 1'b1;
					phase         = WAIT_LITERAL;
				end
			end
		endcase
		if (has_run) begin
			// page closes only at a packet end, runs may overshoot the page
			if (packet_end && decoded_total >= pbrle_pkg::PAGE_BYTES) begin
				r.page_done      = 1'b1;
				r.bytes_consumed = consumed_total;
				clear_page();
			end
			predicted_runs.push_back(r);
		end
	endtask

	task automatic check_run();
		pbrle_pkg::run_t want;
		if (predicted_runs.size() == 0) begin
			$error("run transaction with none predicted: tdata %h tlast %b", m_tdata, m_tlast);
			mismatches = mismatches + 1;
		end else begin
			want = predicted_runs.pop_front();
			if (m_tdata[7:0] !== want.run_value) begin
				$error("run_value: expected %0d, got %0d", want.run_value, m_tdata[7:0]);
				mismatches = mismatches + 1;
			end
			if (m_tdata[15:8] !== want.run_length) begin
				$error("run_length: expected %0d, got %0d", want.run_length, m_tdata[15:8]);
				mismatches = mismatches + 1;
			end
			if (m_tlast !== want.page_done) begin
				$error("page_done: expected %0d, got %0d", want.page_done, m_tlast);
				mismatches = mismatches + 1;
			end
			if (m_tdata[32:16] !== want.bytes_consumed) begin
				$error("bytes_consumed: expected %0d, got %0d", want.bytes_consumed,
					m_tdata[32:16]);
				mismatches = mismatches + 1;
			end
			if (m_tdata[39:33] !== 7'd0) begin
				$error("tdata padding: expected %0d, got %0d", 0, m_tdata[39:33]);
				mismatches = mismatches + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_page();
			predicted_runs.delete();
			mismatches   = 0;
			runs_waiting = 0;
		end else begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_run();
			runs_waiting = predicted_runs.size();
		end
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the packbits run-length decoder: a directed set of
// packets, then random packets biased toward long repeats, with random stalls
// on both channels; a checker predicts every run.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STREAM_BYTES = 1400;
	localparam int CALM_BYTES   = 250;
	localparam int STUCK_LIMIT  = 2000;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [pbrle_pkg::BYTE_W-1:0] s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [pbrle_pkg::OUT_W-1:0]  m_tdata;
	logic                         m_tlast;

	int   mismatches;
	int   runs_waiting;
	int   bytes_sent;
	int   stuck_cycles;
	int   stall_left;
	logic idle_on;

	packbits_run_length_decoder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	pbrle_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.runs_waiting (runs_waiting)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// receiver drops m_tready in random bursts while idle_on is set
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left <= 0;
			m_tready   <= 1'b0;
		end else begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 7);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// no transaction on either side for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$error("no transaction for %0d cycles", stuck_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [pbrle_pkg::BYTE_W-1:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent = bytes_sent + 1;
		if (bytes_sent >= STREAM_BYTES - CALM_BYTES)
			idle_on <= 1'b0;
	endtask

	task automatic send_packet(input logic [pbrle_pkg::BYTE_W-1:0] ctrl);
		int n;
		if ((ctrl & pbrle_pkg::SIGN_BIT) != 0) begin
			send_byte(ctrl);
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(ctrl);
			for (n = 0; n <= ctrl; n++)
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [pbrle_pkg::BYTE_W-1:0] directed[$];
		int                           pick;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		bytes_sent = 0;
		idle_on    = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// longest and shortest repeats, single and short literal packets, data extremes
		directed = {8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hA5, 8'h01, 8'h00, 8'hFF,
			8'h81, 8'h5A, 8'h02, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'h00, 8'h00,
			8'hC0, 8'h3C};
		foreach (directed[i])
			send_byte(directed[i]);

		// mostly long repeats, with some other repeats and literal packets
		while (bytes_sent < STREAM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				send_packet(8'($urandom_range(128, 135)));
			else if (pick < 78)
				send_packet(8'($urandom_range(128, 255)));
			else if (pick < 93)
				send_packet(8'($urandom_range(0, 7)));
			else if (pick < 98)
				send_packet(8'($urandom_range(0, 127)));
			else
				send_packet(8'h7F);
		end
		s_tvalid <= 1'b0;

		wait (runs_waiting == 0);
		repeat (8) @(posedge clk);
		if (runs_waiting != 0)
			$error("%0d predicted runs never came out", runs_waiting);
		if (mismatches == 0 && runs_waiting == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/pbrle_pkg.sv
rtl/pbrle_decode.sv
rtl/pbrle_out_stage.sv
rtl/packbits_run_length_decoder_core.sv
rtl/pbrle_checker.sv
sim/pbrle_checker.sv
sim/testbench.sv
